// ===== hdl/fnms_pkg.sv =====
package fnms_pkg;

  localparam int MAX_WIDTH_DEFAULT   = 32;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int GRID_WIDTH_BITS  = 6;
  localparam int GRID_HEIGHT_BITS = 16;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 6'd32;
  localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 16'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DRAIN,
    ST_DIVIDE,
    ST_EMIT,
    ST_STORE
  } state_t;

  typedef enum logic [1:0] {
    SLOT_UP,
    SLOT_LEFT,
    SLOT_RIGHT,
    SLOT_SELF
  } slot_t;

  typedef struct packed {
    logic  accept;
    logic  cfg_write;
    logic  issue;
    slot_t slot;
    logic  divide;
    logic  load_out;
    logic  store;
    logic  start_burst;
    logic  next_column;
    logic  finish_item;
    logic  finish_frame;
  } cmd_t;

  typedef struct packed {
    logic row_nonzero;
    logic last_item;
    logic burst;
    logic burst_end;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/fnms_ram.sv =====
module fnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fnms_ctrl.sv =====
module fnms_ctrl
  import fnms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    cfg_valid,
  input  status_t st,
  output logic    in_ready,
  output logic    cfg_ready,
  output cmd_t    cmd
);

  state_t state, state_next;
  slot_t  slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= SLOT_UP;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    case (state)
      ST_IDLE: begin
        if (!cfg_valid && in_valid) begin
          slot_next  = SLOT_UP;
          state_next = st.row_nonzero ? ST_GATHER : ST_STORE;
        end
      end
      ST_GATHER: begin
        slot_next = slot_t'(slot + 2'd1);
        if (slot == SLOT_SELF) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_DIVIDE;
      ST_DIVIDE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free) begin
          if (!st.burst) begin
            state_next = ST_STORE;
          end else if (st.burst_end) begin
            state_next = ST_IDLE;
          end else begin
            slot_next  = SLOT_UP;
            state_next = ST_GATHER;
          end
        end
      end
      ST_STORE: begin
        if (st.last_item) begin
          slot_next  = SLOT_UP;
          state_next = ST_GATHER;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        in_ready      = !cfg_valid;
        cmd.cfg_write = cfg_valid;
        cmd.accept    = in_valid && !cfg_valid;
      end
      ST_GATHER: begin
        cmd.issue = 1'b1;
        cmd.slot  = slot;
      end
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_EMIT: begin
        cmd.load_out = st.out_free;
        if (st.out_free && st.burst) begin
          cmd.finish_frame = st.burst_end;
          cmd.next_column  = !st.burst_end;
        end
      end
      ST_STORE: begin
        cmd.store       = 1'b1;
        cmd.start_burst = st.last_item;
        cmd.finish_item = !st.last_item;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/fnms_dp.sv =====
module fnms_dp
  import fnms_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmd_t                             cmd,
  output status_t                          st,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]    pixel_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [SAMPLE_BITS-1:0]    smoothed_value,
  output logic                             last_of_run,
  output logic                             last_of_frame
);

  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH     = 2 * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SUM_W     = SAMPLE_BITS + 3;
  localparam int MAG_W     = SAMPLE_BITS + 2;
  localparam int DIV_SHIFT = (SAMPLE_BITS + 3) | 1;
  localparam int RECIP_W   = DIV_SHIFT - 1;
  localparam int PROD_W    = MAG_W + DIV_SHIFT;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) + 64'd1) / 64'd3;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [GRID_WIDTH_BITS-1:0]  grid_width;
  logic [GRID_HEIGHT_BITS-1:0] grid_height;
  logic [GRID_HEIGHT_BITS-1:0] row_counter;
  logic [CNT_W-1:0]            column_counter;
  logic                        bank_select;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic [CNT_W-1:0]              item_col;
  logic                          item_last;
  logic                          row_ge1;
  logic                          row_ge2;
  logic                          burst;
  logic [CNT_W-1:0]              col_pos;
  logic signed [SUM_W-1:0]       sum;
  logic [2:0]                    cnt;
  logic [SAMPLE_BITS-1:0]        self_value;
  logic                          pend_add;
  logic                          pend_self;
  logic                          neg;
  logic [MAG_W-1:0]              q_small;
  logic [PROD_W-1:0]             prod;

  logic [CNT_W-1:0]            w_eff;
  logic [CNT_W-1:0]            w_last;
  logic [GRID_HEIGHT_BITS-1:0] h_eff;
  logic [CNT_W-1:0]            j_cur;
  logic                        item_is_last;

  logic             rd_en_slot;
  logic             rd_bank;
  logic [CNT_W-1:0] rd_col;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_inc;
  logic [MAG_W-1:0] q;
  logic [MAG_W-1:0] mean;
  logic [SAMPLE_BITS-1:0] result;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (grid_width > GRID_WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width[CNT_W-1:0];
    end
  end

  assign w_last = w_eff - CNT_W'(1);
  assign h_eff  = (grid_height == '0) ? GRID_HEIGHT_BITS'(1) : grid_height;
  assign j_cur  = (column_counter > w_last) ? w_last : column_counter;
  assign item_is_last = (({1'b0, row_counter} + 17'd1) >= {1'b0, h_eff}) && (j_cur == w_last);

  assign st.row_nonzero = (row_counter != '0);
  assign st.last_item   = item_last;
  assign st.burst       = burst;
  assign st.burst_end   = (col_pos == w_last);
  assign st.out_free    = !out_valid || out_ready;

  always_comb begin
    rd_en_slot = 1'b0;
    rd_bank    = bank_select;
    rd_col     = col_pos;
    case (cmd.slot)
      SLOT_UP: begin
        rd_en_slot = burst ? row_ge1 : row_ge2;
        rd_bank    = burst ? !bank_select : bank_select;
      end
      SLOT_LEFT: begin
        rd_en_slot = (col_pos != '0);
        rd_bank    = burst ? bank_select : !bank_select;
        rd_col     = col_pos - CNT_W'(1);
      end
      SLOT_RIGHT: begin
        rd_en_slot = (col_pos != w_last);
        rd_bank    = burst ? bank_select : !bank_select;
        rd_col     = col_pos + CNT_W'(1);
      end
      SLOT_SELF: begin
        rd_en_slot = burst;
      end
      default: rd_en_slot = 1'b0;
    endcase
  end

  assign rd_en = cmd.issue && rd_en_slot;

  always_comb begin
    if (!rd_en_slot) begin
      rd_addr = '0;
    end else if (rd_bank) begin
      rd_addr = ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
    end else begin
      rd_addr = ADDR_W'(rd_col);
    end
  end

  assign wr_addr = bank_select ? ADDR_W'(MAX_WIDTH) + ADDR_W'(item_col) : ADDR_W'(item_col);

  fnms_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (cmd.store),
    .wr_addr(wr_addr),
    .wr_data(sample),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag     = abs_sum[MAG_W-1:0];
  assign mag_inc = mag + MAG_W'(1);
  assign q       = (cnt == 3'd3) ? prod[DIV_SHIFT +: MAG_W] : q_small;
  assign mean    = neg ? MAG_W'(-q) : q;
  assign result  = (cnt == 3'd0) ? self_value : mean[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RESET;
      grid_height    <= GRID_HEIGHT_RESET;
      row_counter    <= '0;
      column_counter <= '0;
      bank_select    <= 1'b0;
      burst          <= 1'b0;
      pend_add       <= 1'b0;
      pend_self      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pend_add  <= rd_en && (cmd.slot != SLOT_SELF);
      pend_self <= rd_en && (cmd.slot == SLOT_SELF);

      if (cmd.cfg_write) begin
        case (cfg_index)
          CFG_GRID_WIDTH: begin
            grid_width     <= cfg_data[GRID_WIDTH_BITS-1:0];
            row_counter    <= '0;
            column_counter <= '0;
          end
          CFG_GRID_HEIGHT: begin
            grid_height    <= cfg_data[GRID_HEIGHT_BITS-1:0];
            row_counter    <= '0;
            column_counter <= '0;
          end
          default: ;
        endcase
      end

      if (cmd.accept) begin
        burst <= 1'b0;
      end else if (cmd.start_burst || cmd.next_column) begin
        burst <= 1'b1;
      end

      if (cmd.finish_item) begin
        if (item_col == w_last) begin
          row_counter    <= row_counter + GRID_HEIGHT_BITS'(1);
          column_counter <= '0;
          bank_select    <= !bank_select;
        end else begin
          column_counter <= item_col + CNT_W'(1);
        end
      end

      if (cmd.finish_frame) begin
        row_counter    <= '0;
        column_counter <= '0;
        bank_select    <= !bank_select;
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample    <= pixel_value;
      item_col  <= j_cur;
      col_pos   <= j_cur;
      item_last <= item_is_last;
      row_ge1   <= (row_counter != '0);
      row_ge2   <= (row_counter > GRID_HEIGHT_BITS'(1));
      sum       <= SUM_W'(pixel_value);
      cnt       <= 3'd1;
    end else if (cmd.start_burst || cmd.next_column) begin
      col_pos <= cmd.start_burst ? '0 : col_pos + CNT_W'(1);
      sum     <= '0;
      cnt     <= 3'd0;
    end else if (pend_add) begin
      sum <= sum + SUM_W'($signed(rd_data));
      cnt <= cnt + 3'd1;
    end

    if (pend_self) begin
      self_value <= rd_data;
    end

    if (cmd.divide) begin
      neg  <= sum[SUM_W-1];
      prod <= PROD_W'(mag_inc) * PROD_W'(RECIP);
      case (cnt)
        3'd2:    q_small <= mag_inc >> 1;
        3'd4:    q_small <= (mag + MAG_W'(2)) >> 2;
        default: q_small <= mag;
      endcase
    end

    if (cmd.load_out) begin
      smoothed_value <= result;
      last_of_run    <= burst ? st.burst_end : !item_last;
      last_of_frame  <= burst && st.burst_end;
    end
  end

endmodule

// ===== hdl/four_neighbour_mean_smoother.sv =====
// Four-neighbour mean smoother: replaces each grid cell by the rounded mean
// (ties away from zero) of its up, left, down and right neighbours inside
// the grid. A single-cell grid passes its sample through.
// Channels: cfg (cfg_index, cfg_data) sets grid_width (index 0) and
// grid_height (index 1); any such write restarts the frame. Samples come in
// on pixel_value in raster order; results leave on smoothed_value with
// last_of_run and last_of_frame. All three use valid/ready.
// An input on the first row is only stored. Any later input gives the
// result for the cell above it: the control runs the gather, drain,
// divide and emit states, then stores the input. The frame's last input
// then gives the whole last row, one word per column, in the same way.
// The single read port of the line store fetches one neighbour per cycle.
// Reset restores width 32 and height 1 and starts a new frame; the line
// store is not cleared. A result waits in the output register while the
// receiver stalls; the next item is still taken meanwhile, but the block
// holds a second result until the first has left.
module four_neighbour_mean_smoother
  import fnms_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] pixel_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] smoothed_value,
  output logic                          last_of_run,
  output logic                          last_of_frame
);

  cmd_t    cmd;
  status_t st;

  fnms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_valid(cfg_valid),
    .st       (st),
    .in_ready (in_ready),
    .cfg_ready(cfg_ready),
    .cmd      (cmd)
  );

  fnms_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_value   (pixel_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .smoothed_value(smoothed_value),
    .last_of_run   (last_of_run),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== dv/tb_four_neighbour_mean_smoother.sv =====
module tb_four_neighbour_mean_smoother
  import fnms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned ITEM_TARGET      = 500;
  localparam int unsigned QUIET_TAIL_START = 420;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef logic signed [SAMPLE_BITS_DEFAULT-1:0] sample_t;

  class neighbour_mean_board;
    typedef struct {
      sample_t value;
      bit      run_end;
      bit      frame_end;
    } smoothed_word_t;

    sample_t                     rows [2][MAX_WIDTH_DEFAULT];
    int unsigned                 row_idx;
    int unsigned                 col_idx;
    bit                          bank;
    logic [GRID_WIDTH_BITS-1:0]  width_reg;
    logic [GRID_HEIGHT_BITS-1:0] height_reg;
    smoothed_word_t              awaited_means [$];
    int unsigned                 error_count;

    function void reset_state();
      foreach (rows[b, c]) rows[b][c] = '0;
      row_idx    = 0;
      col_idx    = 0;
      bank       = 1'b0;
      width_reg  = GRID_WIDTH_RESET;
      height_reg = GRID_HEIGHT_RESET;
      awaited_means.delete();
      error_count = 0;
    endfunction

    function int unsigned pending();
      return awaited_means.size();
    endfunction

    function sample_t rounded_mean(int sum, int count);
      int mag;
      int q;
      mag = (sum < 0) ? -sum : sum;
      q   = (2 * mag + count) / (2 * count);
      return sample_t'((sum < 0) ? -q : q);
    endfunction

    function void push_mean(sample_t value, bit run_end, bit frame_end);
      smoothed_word_t word;
      word.value     = value;
      word.run_end   = run_end;
      word.frame_end = frame_end;
      awaited_means.push_back(word);
    endfunction

    function void note_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
      case (index)
        CFG_GRID_WIDTH: begin
          width_reg = data[GRID_WIDTH_BITS-1:0];
          row_idx   = 0;
          col_idx   = 0;
        end
        CFG_GRID_HEIGHT: begin
          height_reg = data[GRID_HEIGHT_BITS-1:0];
          row_idx    = 0;
          col_idx    = 0;
        end
        default: ;
      endcase
    endfunction

    function void absorb_pixel(sample_t x);
      int unsigned w;
      int unsigned h;
      int unsigned j;
      bit          cur;
      bit          prv;
      bit          last;
      int          sum;
      int          count;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
      h = height_reg;
      if (h < 1) h = 1;
      j = col_idx;
      if (j >= w) j = w - 1;
      cur  = bank;
      prv  = ~bank;
      last = (row_idx + 1 >= h) && (j + 1 == w);

      if (row_idx >= 1) begin
        sum   = x;
        count = 1;
        if (row_idx >= 2) begin
          sum += rows[cur][j];
          count++;
        end
        if (j >= 1) begin
          sum += rows[prv][j-1];
          count++;
        end
        if (j + 1 < w) begin
          sum += rows[prv][j+1];
          count++;
        end
        push_mean(rounded_mean(sum, count), !last, 1'b0);
      end
      rows[cur][j] = x;

      if (last) begin
        for (int unsigned c = 0; c < w; c++) begin
          sum   = 0;
          count = 0;
          if (row_idx >= 1) begin
            sum += rows[prv][c];
            count++;
          end
          if (c >= 1) begin
            sum += rows[cur][c-1];
            count++;
          end
          if (c + 1 < w) begin
            sum += rows[cur][c+1];
            count++;
          end
          if (count == 0)
            push_mean(rows[cur][c], c + 1 == w, c + 1 == w);
          else
            push_mean(rounded_mean(sum, count), c + 1 == w, c + 1 == w);
        end
        row_idx = 0;
        col_idx = 0;
        bank    = prv;
      end else if (j + 1 == w) begin
        row_idx = (row_idx + 1) & 16'hFFFF;
        col_idx = 0;
        bank    = prv;
      end else begin
        col_idx = j + 1;
      end
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task match_smoothed(sample_t value, logic run_end, logic frame_end);
      smoothed_word_t want;
      if (awaited_means.size() == 0) begin
        report_mismatch($sformatf("unexpected word, value %0d", value));
        return;
      end
      want = awaited_means.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("smoothed_value %0d, want %0d", value, want.value));
      if (run_end !== want.run_end)
        report_mismatch($sformatf("last_of_run %b, want %b", run_end, want.run_end));
      if (frame_end !== want.frame_end)
        report_mismatch($sformatf("last_of_frame %b, want %b", frame_end, want.frame_end));
    endtask
  endclass

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index   = CFG_GRID_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  sample_t                   pixel_value = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  sample_t                   smoothed_value;
  logic                      last_of_run;
  logic                      last_of_frame;

  neighbour_mean_board board;
  int unsigned         items_sent   = 0;
  int unsigned         quiet_cycles = 0;
  bit                  idling       = 1'b1;
  bit                  hold_request = 1'b0;

  four_neighbour_mean_smoother u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .smoothed_value(smoothed_value),
    .last_of_run   (last_of_run),
    .last_of_frame (last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.match_smoothed(smoothed_value, last_of_run, last_of_frame);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // receiver: long hold-off on request, random stall bursts while idling
  initial begin
    forever begin
      @(posedge clk);
      if (rst)
        out_ready <= 1'b0;
      else if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else
        out_ready <= 1'b1;
    end
  end

  function automatic sample_t random_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'(int'($urandom_range(0, 6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // leaves in_valid high: the caller offers the next word or drops valid in the same step
  task automatic drive_pixel(sample_t value);
    int unsigned gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.absorb_pixel(value);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data,
                           bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_register(index, data);
    if (!keep_valid) cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [CFG_DATA_BITS-1:0] width_word,
                          logic [CFG_DATA_BITS-1:0] height_word);
    wait_drained();
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_UNMAPPED_LO, CFG_DATA_BITS'($urandom), 1'b1);
      else
        write_reg(CFG_UNMAPPED_HI, CFG_DATA_BITS'($urandom), 1'b1);
    end
    write_reg(CFG_GRID_WIDTH, width_word, 1'b1);
    write_reg(CFG_GRID_HEIGHT, height_word, 1'b0);
  endtask

  initial begin
    sample_t                    pattern [$];
    logic [GRID_WIDTH_BITS-1:0] width_code;
    logic [9:0]                 width_upper;
    logic [CFG_DATA_BITS-1:0]   height_word;
    int unsigned                eff_w;
    int unsigned                eff_h;
    int unsigned                burst_len;

    board = new;
    board.reset_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_grid(16'd1, 16'd1);
    drive_pixel(16'sh7FFF);
    drive_pixel(16'sh8000);

    // width 0 acts as 1, height 0 acts as 1
    set_grid(16'hFFC0, 16'd0);
    drive_pixel(-5);

    set_grid(16'd1, 16'd3);
    pattern = '{-32768, 32767, -32768};
    foreach (pattern[k]) drive_pixel(pattern[k]);

    set_grid(16'd3, 16'd3);
    pattern = '{1, -1, 0, 0, 3, -3, 32767, -32768, 2};
    foreach (pattern[k]) drive_pixel(pattern[k]);

    // unmapped writes mid-frame leave the frame running
    set_grid(16'd2, 16'd2);
    drive_pixel(16'sh8000);
    drive_pixel(16'sh7FFF);
    wait_drained();
    write_reg(CFG_UNMAPPED_LO, CFG_DATA_BITS'($urandom), 1'b1);
    write_reg(CFG_UNMAPPED_HI, CFG_DATA_BITS'($urandom), 1'b0);
    drive_pixel(1);
    drive_pixel(-2);

    // width above the store size, tallest frame, abandoned early
    set_grid(16'hFFFF, 16'hFFFF);
    repeat (3) drive_pixel(random_pixel());

    // fill the block while the receiver holds off
    set_grid(16'd32, 16'd4);
    hold_request = 1'b1;
    repeat (128) drive_pixel(random_pixel());

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_TAIL_START) idling = 1'b0;
      case ($urandom_range(0, 9))
        0:       width_code = 6'd0;
        1:       width_code = GRID_WIDTH_BITS'($urandom_range(33, 63));
        2:       width_code = 6'd32;
        3:       width_code = GRID_WIDTH_BITS'($urandom_range(9, 31));
        default: width_code = GRID_WIDTH_BITS'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       height_word = 16'd0;
        1:       height_word = CFG_DATA_BITS'($urandom_range(7, 65535));
        default: height_word = CFG_DATA_BITS'($urandom_range(1, 6));
      endcase
      eff_w = (width_code == 0) ? 1 : ((width_code > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT
                                                                         : width_code);
      eff_h = (height_word == 0) ? 1 : height_word;
      if (eff_h <= 6) begin
        burst_len = eff_w * eff_h * ((eff_w > 8) ? 1 : $urandom_range(1, 3));
        if ($urandom_range(0, 4) == 0 && eff_w * eff_h > 1)
          burst_len += $urandom_range(1, eff_w * eff_h - 1);
      end else
        burst_len = $urandom_range(1, 3 * eff_w);
      if (burst_len > ITEM_TARGET - items_sent) burst_len = ITEM_TARGET - items_sent;
      width_upper = 10'($urandom);
      set_grid({width_upper, width_code}, height_word);
      repeat (burst_len) drive_pixel(random_pixel());
    end

    wait_drained();
    if (board.error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
